### design/lsra_pkg.sv
// ----------------------------------------------------------------------------
// lsra_pkg: shared types and constants of the linear scan register allocator
// Payload words, cell control and candidate records, reset values of the
// register masks, and small helper functions.
// ----------------------------------------------------------------------------
package lsra_pkg;

  // field widths
  localparam int NumSlots = 16;
  localparam int RegW     = 4;
  localparam int VregW    = 10;
  localparam int PosW     = 16;
  localparam int MaskW    = 16;
  localparam int AgeW     = 11;
  localparam int SpillW   = 11;
  localparam int SlotW    = 10;
  localparam int FrameW   = 14;

  // saturation limits
  localparam logic [AgeW-1:0]   AgeMax   = 11'd2047;
  localparam logic [SpillW-1:0] SpillMax = 11'd1024;
  localparam logic [SlotW-1:0]  SlotMax  = 10'd1023;

  // register reset values
  localparam logic [MaskW-1:0] CallerSavedRst = 16'h0FC7;
  localparam logic [MaskW-1:0] CalleeSavedRst = 16'hF028;
  localparam logic [MaskW-1:0] ReservedRst    = 16'h0010;

  // result outcome codes
  localparam logic OutcomeAssigned = 1'b0;
  localparam logic OutcomeSpilled  = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgCallerSaved = 2'd0,
    CfgCalleeSaved = 2'd1,
    CfgReserved    = 2'd2
  } lsra_cfg_e;

  // input word
  typedef struct packed {
    logic             first_of_run;
    logic [VregW-1:0] vreg;
    logic [PosW-1:0]  interval_start;
    logic [PosW-1:0]  interval_end;
    logic             pin_en;
    logic [RegW-1:0]  pin_reg;
  } lsra_in_t;

  // output word
  typedef struct packed {
    logic [VregW-1:0]  out_vreg;
    logic              outcome;
    logic [RegW-1:0]   assigned_reg;
    logic [SlotW-1:0]  slot_num;
    logic [MaskW-1:0]  callee_used_mask;
    logic [FrameW-1:0] frame_bytes;
    logic              last;
  } lsra_out_t;

  // one pending result without the run-wide fields
  typedef struct packed {
    logic [VregW-1:0] vreg;
    logic             outcome;
    logic [RegW-1:0]  assigned_reg;
    logic [SlotW-1:0] slot_num;
  } lsra_res_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic             clear;
    logic             expire_en;
    logic [PosW-1:0]  start;
    logic             wr_en;
    logic [RegW-1:0]  wr_idx;
    logic [VregW-1:0] wr_vreg;
    logic [PosW-1:0]  wr_end;
    logic             wr_fixed;
    logic [AgeW-1:0]  wr_age;
  } lsra_ctrl_t;

  // spill candidate handed from cell to cell
  typedef struct packed {
    logic             found;
    logic [RegW-1:0]  idx;
    logic [VregW-1:0] vreg;
    logic [PosW-1:0]  end_pos;
    logic [AgeW-1:0]  age;
  } lsra_cand_t;

  // per-cell status seen by the sequencer
  typedef struct packed {
    logic             valid;
    logic             expiring;
    logic [VregW-1:0] vreg;
  } lsra_status_t;

  // allocatable pool
  function automatic logic [MaskW-1:0] pool_f(input logic [MaskW-1:0] caller,
                                              input logic [MaskW-1:0] callee,
                                              input logic [MaskW-1:0] reserved,
                                              input logic [MaskW-1:0] tmask);
    return (caller | callee) & ~reserved & tmask;
  endfunction

  // lowest set bit, top index when none is set
  function automatic logic [RegW-1:0] lowest_f(input logic [MaskW-1:0] m);
    logic [RegW-1:0] r;
    r = RegW'(NumSlots - 1);
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (m[i]) r = RegW'(i);
    end
    return r;
  endfunction

endpackage

### design/lsra_cell.sv
// ----------------------------------------------------------------------------
// lsra_cell: one slot of the active table
// Holds the interval living in one physical register, flags its expiry and
// merges itself into the spill candidate passed along the chain.
// ----------------------------------------------------------------------------
module lsra_cell import lsra_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lsra_ctrl_t   ctrl_i,
  input  lsra_cand_t   cand_i,
  output lsra_cand_t   cand_o,
  output lsra_status_t status_o
);

  logic             valid_q, valid_d;
  logic [VregW-1:0] vreg_q;
  logic [PosW-1:0]  end_q;
  logic             fixed_q;
  logic [AgeW-1:0]  age_q;
  logic             wr_hit;
  logic             expiring;
  logic             take;
  lsra_cand_t       cand_q, cand_d;

  // slot update
  assign wr_hit   = ctrl_i.wr_en && (ctrl_i.wr_idx == RegW'(CELL_IDX));
  assign expiring = valid_q && ctrl_i.expire_en && (end_q < ctrl_i.start);

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (wr_hit) begin
      valid_d = 1'b1;
    end else if (expiring) begin
      valid_d = 1'b0;
    end
  end

  // furthest end wins, then lowest age, earlier cell on a full tie
  assign take = valid_q && !fixed_q &&
                (!cand_i.found || (end_q > cand_i.end_pos) ||
                 ((end_q == cand_i.end_pos) && (age_q < cand_i.age)));

  always_comb begin
    cand_d = cand_i;
    if (take) begin
      cand_d.found   = 1'b1;
      cand_d.idx     = RegW'(CELL_IDX);
      cand_d.vreg    = vreg_q;
      cand_d.end_pos = end_q;
      cand_d.age     = age_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cand_q  <= '0;
    end else begin
      valid_q <= valid_d;
      cand_q  <= cand_d;
    end
  end

  // slot payload
  always_ff @(posedge clk_i) begin
    if (wr_hit && !ctrl_i.clear) begin
      vreg_q  <= ctrl_i.wr_vreg;
      end_q   <= ctrl_i.wr_end;
      fixed_q <= ctrl_i.wr_fixed;
      age_q   <= ctrl_i.wr_age;
    end
  end

  assign cand_o            = cand_q;
  assign status_o.valid    = valid_q;
  assign status_o.expiring = expiring;
  assign status_o.vreg     = vreg_q;

endmodule

### design/linear_scan_register_allocator.sv
// ----------------------------------------------------------------------------
// linear_scan_register_allocator: linear scan register allocation engine
// Assigns physical registers or spill slots to live intervals sorted by start.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one live interval
//   per word; output channel (out_valid_o/out_ready_i/out_data_o) returns one
//   or two result words per interval, the final one flagged by last; a word
//   whose vreg is NUM_VREGS or more gets no result. Configuration
//   writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) load the register masks; the
//   free pool picks them up at run start. Each interval passes the expire and
//   decide states before its first result word is shown; when no register is
//   free the spill candidate walks the cell chain, one cell per register and
//   at most 16 cells, before the decision. The block handles one interval at
//   a time, and the chain walk adds a wait set by the number of cells.
//   A new word is taken the cycle after the last result word leaves.
//   A stalled receiver holds the result word and the block waits.
//   Reset empties the active table, loads the free pool from the reset masks,
//   zeroes the spill and age counts and callee-used mask; no clearing pass.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator import lsra_pkg::*; #(
  parameter int NUM_REGS      = 16,
  parameter int NUM_VREGS     = 1024,
  parameter int POSITION_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lsra_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lsra_out_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [MaskW-1:0] cfg_wdata_i
);

  localparam int RegLimit = (NUM_REGS < NumSlots) ? NUM_REGS : NumSlots;
  localparam int PosBits  = (POSITION_BITS < PosW) ? POSITION_BITS : PosW;
  localparam int CntW     = $clog2(RegLimit);
  localparam logic [MaskW-1:0] TableMask = MaskW'((1 << RegLimit) - 1);
  localparam logic [PosW-1:0]  PosMask   = PosW'((1 << PosBits) - 1);
  localparam logic [MaskW-1:0] PoolRst   =
    pool_f(CallerSavedRst, CalleeSavedRst, ReservedRst, TableMask);

  typedef enum logic [2:0] {
    StIdle,
    StExpire,
    StDecide,
    StSearch,
    StEmit
  } state_e;

  // configuration registers
  logic [MaskW-1:0] caller_q, callee_q, reserved_q;
  logic [MaskW-1:0] pool_live;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caller_q   <= CallerSavedRst;
      callee_q   <= CalleeSavedRst;
      reserved_q <= ReservedRst;
    end else if (cfg_we_i) begin
      case (lsra_cfg_e'(cfg_idx_i))
        CfgCallerSaved: caller_q   <= cfg_wdata_i;
        CfgCalleeSaved: callee_q   <= cfg_wdata_i;
        CfgReserved:    reserved_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign pool_live = pool_f(caller_q, callee_q, reserved_q, TableMask);

  // sequencer registers
  state_e           state_q, state_d;
  lsra_in_t         item_q, item_d;
  lsra_res_t        res_q [2];
  lsra_res_t        res_d [2];
  logic             two_q, two_d;
  logic             emit_idx_q, emit_idx_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [MaskW-1:0] free_q, free_d;
  logic [MaskW-1:0] callee_used_q, callee_used_d;
  logic [SpillW-1:0] spill_q, spill_d;
  logic [AgeW-1:0]  age_q, age_d;

  // cell chain
  lsra_ctrl_t   ctrl;
  lsra_cand_t   cand_w   [RegLimit+1];
  lsra_status_t status_w [RegLimit];

  assign cand_w[0] = '0;

  for (genvar gi = 0; gi < RegLimit; gi++) begin : g_cell
    lsra_cell #(
      .CELL_IDX(gi)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .cand_i  (cand_w[gi]),
      .cand_o  (cand_w[gi+1]),
      .status_o(status_w[gi])
    );
  end

  // gather cell status into full-width vectors
  logic [MaskW-1:0] valid_vec, expire_vec;
  logic [VregW-1:0] slot_vreg_w [NumSlots];

  always_comb begin
    valid_vec  = '0;
    expire_vec = '0;
    for (int i = 0; i < NumSlots; i++) begin
      slot_vreg_w[i] = '0;
    end
    for (int i = 0; i < RegLimit; i++) begin
      valid_vec[i]   = status_w[i].valid;
      expire_vec[i]  = status_w[i].expiring;
      slot_vreg_w[i] = status_w[i].vreg;
    end
  end

  // derived values used by the decision
  logic [SlotW-1:0]  slot_now;
  logic [SpillW-1:0] spill_inc;
  logic [AgeW-1:0]   age_inc;
  logic              fixed_ok;
  logic              vreg_ok;
  logic [MaskW-1:0]  avail_caller, avail_callee, avail;
  logic [RegW-1:0]   pick;
  logic [MaskW-1:0]  pick_bit, fixed_bit;
  lsra_cand_t        best;

  assign slot_now       = (spill_q > SpillW'(SlotMax)) ? SlotMax : spill_q[SlotW-1:0];
  assign spill_inc      = (spill_q < SpillMax) ? spill_q + 1'b1 : spill_q;
  assign age_inc        = (age_q < AgeMax) ? age_q + 1'b1 : age_q;
  assign fixed_ok       = item_q.pin_en && ({1'b0, item_q.pin_reg} < (RegW+1)'(RegLimit));
  assign vreg_ok        = {7'b0, in_data_i.vreg} < 17'(NUM_VREGS);
  assign avail_caller   = free_q & caller_q & TableMask;
  assign avail_callee   = free_q & callee_q & TableMask;
  assign avail          = (avail_caller != '0) ? avail_caller : avail_callee;
  assign pick           = lowest_f(avail);
  assign pick_bit       = MaskW'(1) << pick;
  assign fixed_bit      = MaskW'(1) << item_q.pin_reg;
  assign best           = cand_w[RegLimit];

  // sequencer next state
  always_comb begin
    state_d       = state_q;
    item_d        = item_q;
    res_d[0]      = res_q[0];
    res_d[1]      = res_q[1];
    two_d         = two_q;
    emit_idx_d    = emit_idx_q;
    cnt_d         = cnt_q;
    free_d        = free_q;
    callee_used_d = callee_used_q;
    spill_d       = spill_q;
    age_d         = age_q;

    ctrl          = '0;
    ctrl.start    = item_q.interval_start;
    ctrl.wr_vreg  = item_q.vreg;
    ctrl.wr_end   = item_q.interval_end;

    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;

    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d                = in_data_i;
          item_d.interval_start = in_data_i.interval_start & PosMask;
          item_d.interval_end   = in_data_i.interval_end & PosMask;
          if (in_data_i.first_of_run) begin
            ctrl.clear    = 1'b1;
            free_d        = pool_live;
            callee_used_d = '0;
            spill_d       = '0;
            age_d         = '0;
          end
          state_d = vreg_ok ? StExpire : StIdle;
        end
      end

      // retire intervals ending before the new start
      StExpire: begin
        ctrl.expire_en = 1'b1;
        free_d         = free_q | (expire_vec & pool_live);
        state_d        = StDecide;
      end

      StDecide: begin
        emit_idx_d = 1'b0;
        if (fixed_ok) begin
          // fixed register: evict any holder first
          ctrl.wr_en    = 1'b1;
          ctrl.wr_idx   = item_q.pin_reg;
          ctrl.wr_fixed = 1'b1;
          ctrl.wr_age   = age_q;
          age_d         = age_inc;
          free_d        = free_q & ~fixed_bit;
          callee_used_d = callee_used_q | (fixed_bit & callee_q);
          if (valid_vec[item_q.pin_reg]) begin
            res_d[0] = '{vreg: slot_vreg_w[item_q.pin_reg], outcome: OutcomeSpilled,
                         assigned_reg: '0, slot_num: slot_now};
            res_d[1] = '{vreg: item_q.vreg, outcome: OutcomeAssigned,
                         assigned_reg: item_q.pin_reg, slot_num: '0};
            two_d    = 1'b1;
            spill_d  = spill_inc;
          end else begin
            res_d[0] = '{vreg: item_q.vreg, outcome: OutcomeAssigned,
                         assigned_reg: item_q.pin_reg, slot_num: '0};
            two_d    = 1'b0;
          end
          state_d = StEmit;
        end else if (avail != '0) begin
          // lowest free register, caller-saved first
          ctrl.wr_en    = 1'b1;
          ctrl.wr_idx   = pick;
          ctrl.wr_fixed = 1'b0;
          ctrl.wr_age   = age_q;
          age_d         = age_inc;
          free_d        = free_q & ~pick_bit;
          if (avail_caller == '0) begin
            callee_used_d = callee_used_q | pick_bit;
          end
          res_d[0] = '{vreg: item_q.vreg, outcome: OutcomeAssigned,
                       assigned_reg: pick, slot_num: '0};
          two_d    = 1'b0;
          state_d  = StEmit;
        end else begin
          cnt_d   = '0;
          state_d = StSearch;
        end
      end

      // wait for the candidate to reach the end of the chain
      StSearch: begin
        if (cnt_q == CntW'(RegLimit - 1)) begin
          spill_d = spill_inc;
          if (best.found && (best.end_pos > item_q.interval_end)) begin
            ctrl.wr_en    = 1'b1;
            ctrl.wr_idx   = best.idx;
            ctrl.wr_fixed = 1'b0;
            ctrl.wr_age   = best.age;
            res_d[0] = '{vreg: best.vreg, outcome: OutcomeSpilled,
                         assigned_reg: '0, slot_num: slot_now};
            res_d[1] = '{vreg: item_q.vreg, outcome: OutcomeAssigned,
                         assigned_reg: best.idx, slot_num: '0};
            two_d    = 1'b1;
          end else begin
            res_d[0] = '{vreg: item_q.vreg, outcome: OutcomeSpilled,
                         assigned_reg: '0, slot_num: slot_now};
            two_d    = 1'b0;
          end
          state_d = StEmit;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (emit_idx_q == two_q) begin
            state_d = StIdle;
          end else begin
            emit_idx_d = 1'b1;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // sequencer state and run counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      two_q         <= 1'b0;
      emit_idx_q    <= 1'b0;
      cnt_q         <= '0;
      free_q        <= PoolRst;
      callee_used_q <= '0;
      spill_q       <= '0;
      age_q         <= '0;
    end else begin
      state_q       <= state_d;
      two_q         <= two_d;
      emit_idx_q    <= emit_idx_d;
      cnt_q         <= cnt_d;
      free_q        <= free_d;
      callee_used_q <= callee_used_d;
      spill_q       <= spill_d;
      age_q         <= age_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    res_q[0] <= res_d[0];
    res_q[1] <= res_d[1];
  end

  // output word
  assign out_data_o.out_vreg         = res_q[emit_idx_q].vreg;
  assign out_data_o.outcome          = res_q[emit_idx_q].outcome;
  assign out_data_o.assigned_reg     = res_q[emit_idx_q].assigned_reg;
  assign out_data_o.slot_num         = res_q[emit_idx_q].slot_num;
  assign out_data_o.callee_used_mask = callee_used_q;
  assign out_data_o.frame_bytes      = {spill_q + SpillW'(spill_q[0]), 3'b000};
  assign out_data_o.last             = (emit_idx_q == two_q);

`ifndef ASSERT_OFF
  // a register held by a live interval is never in the free set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q & valid_vec) == '0)
    else $error("free mask overlaps an active slot");

  // spill count saturates at its limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    spill_q <= SpillMax)
    else $error("spill counter beyond limit");

  // no new word is taken while a result is still shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while result pending");

  // taking the final result word frees the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last |=> in_ready_o)
    else $error("block not idle after final result");

  // an accepted word never yields a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result shown too early");
`endif

endmodule
